/* src/allm_pkg.sv */
// Shared types, constants and microcode ROM for the linked list manager.
`timescale 1ns / 1ps
`default_nettype none
package allm_pkg;

  localparam int ALLM_DEPTH       = 256;
  localparam int ALLM_AW          = $clog2(ALLM_DEPTH);
  localparam int ALLM_VALUE_WIDTH = 32;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // sequencer steps
  typedef enum logic [3:0] {
    S_INIT, S_IDLE,
    S_I0, S_I1, S_I2, S_I3,
    S_D0, S_D1, S_D2, S_D3
  } step_t;

  // link RAM address source
  typedef enum logic [2:0] {A_POS, A_FREE, A_PRV, A_NXT, A_INIT} asel_t;
  // next_link write data
  typedef enum logic [1:0] {NW_FREE, NW_NXT, NW_INIT} nwsel_t;
  // prev_link write data
  typedef enum logic [1:0] {PW_ZERO, PW_POS, PW_FREE, PW_PRV} pwsel_t;
  // in_use write data
  typedef enum logic [1:0] {UW_CLR, UW_SET, UW_INIT} uwsel_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_INS, CHK_DEL} chk_t;
  typedef enum logic [1:0] {UPD_NONE, UPD_INS, UPD_DEL} upd_t;
  typedef enum logic [1:0] {J_GO, J_SWEEP, J_DISPATCH} jmp_t;

  typedef struct packed {
    logic   accept;
    logic   next_we;
    asel_t  next_asel;
    nwsel_t next_wsel;
    logic   prev_we;
    asel_t  prev_asel;
    pwsel_t prev_wsel;
    logic   use_we;
    asel_t  use_asel;
    uwsel_t use_wsel;
    logic   val_we;
    logic   cap_n;
    logic   cap_p;
    logic   cap_fn;
    chk_t   chk;
    upd_t   upd;
    logic   fin;
    jmp_t   jmp;
    step_t  nxt;
  } cword_t;

  // microcode ROM: one control word per step
  function automatic cword_t ucode(input step_t s);
    cword_t c;
    c     = '0;
    c.nxt = S_IDLE;
    unique case (s)
      S_INIT: begin
        c.next_we   = 1'b1;
        c.next_asel = A_INIT;
        c.next_wsel = NW_INIT;
        c.prev_we   = 1'b1;
        c.prev_asel = A_INIT;
        c.prev_wsel = PW_ZERO;
        c.use_we    = 1'b1;
        c.use_asel  = A_INIT;
        c.use_wsel  = UW_INIT;
        c.jmp       = J_SWEEP;
        c.nxt       = S_IDLE;
      end
      S_IDLE: begin
        c.accept = 1'b1;
        c.jmp    = J_DISPATCH;
        c.nxt    = S_IDLE;
      end
      S_I0: begin
        c.next_asel = A_POS;
        c.use_asel  = A_POS;
        c.nxt       = S_I1;
      end
      S_I1: begin
        c.cap_n     = 1'b1;
        c.next_asel = A_FREE;
        c.use_asel  = A_POS;
        c.chk       = CHK_INS;
        c.nxt       = S_I2;
      end
      S_I2: begin
        c.cap_fn    = 1'b1;
        c.next_we   = 1'b1;
        c.next_asel = A_POS;
        c.next_wsel = NW_FREE;
        c.prev_we   = 1'b1;
        c.prev_asel = A_FREE;
        c.prev_wsel = PW_POS;
        c.use_we    = 1'b1;
        c.use_asel  = A_FREE;
        c.use_wsel  = UW_SET;
        c.val_we    = 1'b1;
        c.nxt       = S_I3;
      end
      S_I3: begin
        c.next_we   = 1'b1;
        c.next_asel = A_FREE;
        c.next_wsel = NW_NXT;
        c.prev_we   = 1'b1;
        c.prev_asel = A_NXT;
        c.prev_wsel = PW_FREE;
        c.upd       = UPD_INS;
        c.fin       = 1'b1;
        c.nxt       = S_IDLE;
      end
      S_D0: begin
        c.next_asel = A_POS;
        c.prev_asel = A_POS;
        c.use_asel  = A_POS;
        c.nxt       = S_D1;
      end
      S_D1: begin
        c.cap_n     = 1'b1;
        c.cap_p     = 1'b1;
        c.use_asel  = A_POS;
        c.chk       = CHK_DEL;
        c.nxt       = S_D2;
      end
      S_D2: begin
        c.next_we   = 1'b1;
        c.next_asel = A_PRV;
        c.next_wsel = NW_NXT;
        c.prev_we   = 1'b1;
        c.prev_asel = A_NXT;
        c.prev_wsel = PW_PRV;
        c.use_we    = 1'b1;
        c.use_asel  = A_POS;
        c.use_wsel  = UW_CLR;
        c.nxt       = S_D3;
      end
      S_D3: begin
        c.next_we   = 1'b1;
        c.next_asel = A_POS;
        c.next_wsel = NW_FREE;
        c.prev_we   = 1'b1;
        c.prev_asel = A_POS;
        c.prev_wsel = PW_ZERO;
        c.upd       = UPD_DEL;
        c.fin       = 1'b1;
        c.nxt       = S_IDLE;
      end
      default: begin
        c.jmp = J_GO;
        c.nxt = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/allm_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module allm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/array_linked_list_manager_core.sv */
// Array-backed doubly linked list with free list, driven by a microcoded sequencer.
// An insert or delete runs the sequencer steps I0-I3 or D0-D3 after the accept step; a
//   rejected request (full, invalid slot) ends at step I1 or D1. Result is registered.
// A new request is taken only in the idle step, after the last one has finished; each
//   single-ported RAM takes at most two reads then two writes, one access per step.
// Reset: synchronous active-low; afterwards a pass over all 256 slots initializes the
//   link RAMs (in_tready stays low during it).
`timescale 1ns / 1ps
`default_nettype none
module array_linked_list_manager_core #(
  parameter int VALUE_WIDTH = allm_pkg::ALLM_VALUE_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // cmd[0], position[8:1], value[40:9], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata   // status[1:0], slot[9:2], count[17:10], zero pad
);

  localparam int AW = allm_pkg::ALLM_AW;

  // sequencer
  allm_pkg::step_t  step_r, step_nxt;
  allm_pkg::cword_t cw;
  logic [AW-1:0]    init_cnt_r, init_cnt_nxt;

  // request and datapath registers
  logic                   cmd_r, cmd_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]          n_r, n_nxt;     // successor of the node
  logic [AW-1:0]          p_r, p_nxt;     // predecessor of the node
  logic [AW-1:0]          fn_r, fn_nxt;   // successor of free head on the free list
  logic [AW-1:0]          free_head_r, free_head_nxt;
  logic [AW-1:0]          count_r, count_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [7:0] out_slot_r, out_slot_nxt;
  logic [7:0] out_count_r, out_count_nxt;

  // RAM ports
  logic [AW-1:0] next_addr, next_wdata, next_rdata;
  logic [AW-1:0] prev_addr, prev_wdata, prev_rdata;
  logic [AW-1:0] use_addr;
  logic          use_wdata, use_rdata;
  logic [AW-1:0] init_link;

  // step control
  logic       chk_fail;
  logic [1:0] fail_status;
  logic       finish;
  logic       adv;
  logic       accept;

  function automatic logic [AW-1:0] pick_addr(
    input allm_pkg::asel_t sel,
    input logic [AW-1:0]   pos,
    input logic [AW-1:0]   fh,
    input logic [AW-1:0]   prv,
    input logic [AW-1:0]   nxt,
    input logic [AW-1:0]   ini
  );
    logic [AW-1:0] a;
    unique case (sel)
      allm_pkg::A_POS:  a = pos;
      allm_pkg::A_FREE: a = fh;
      allm_pkg::A_PRV:  a = prv;
      allm_pkg::A_NXT:  a = nxt;
      allm_pkg::A_INIT: a = ini;
      default:          a = pos;
    endcase
    return a;
  endfunction

  // control word of the current step
  always_comb begin
    cw = allm_pkg::ucode(step_r);
  end

  assign in_tready = cw.accept;
  assign accept    = in_tvalid & cw.accept;

  // reset image of next_link: sentinel to itself, free chain ascending, last slot to 0
  assign init_link = (init_cnt_r == '0) ? '0 : init_cnt_r + AW'(1);

  // validity checks on the read data of the first step
  always_comb begin
    chk_fail    = 1'b0;
    fail_status = allm_pkg::ST_INVALID;
    unique case (cw.chk)
      allm_pkg::CHK_NONE: chk_fail = 1'b0;
      allm_pkg::CHK_INS: begin
        chk_fail    = !use_rdata || (free_head_r == '0);
        fail_status = use_rdata ? allm_pkg::ST_FULL : allm_pkg::ST_INVALID;
      end
      allm_pkg::CHK_DEL: chk_fail = !use_rdata || (pos_r == '0);
      default:           chk_fail = 1'b0;
    endcase
  end

  // a finishing step waits while the result register is still occupied
  assign finish = cw.fin | chk_fail;
  assign adv    = !(finish && out_valid_r && !out_tready);

  // next step
  always_comb begin
    step_nxt = step_r;
    priority if (!adv) begin
      step_nxt = step_r;
    end else if (chk_fail) begin
      step_nxt = allm_pkg::S_IDLE;
    end else begin
      unique case (cw.jmp)
        allm_pkg::J_GO:    step_nxt = cw.nxt;
        allm_pkg::J_SWEEP: step_nxt = (&init_cnt_r) ? cw.nxt : step_r;
        allm_pkg::J_DISPATCH: begin
          if (in_tvalid) begin
            step_nxt = (in_tdata[0] == allm_pkg::CMD_DELETE) ? allm_pkg::S_D0
                                                              : allm_pkg::S_I0;
          end
        end
        default: step_nxt = allm_pkg::S_IDLE;
      endcase
    end
  end

  // RAM address and write-data selection
  always_comb begin
    next_addr = pick_addr(cw.next_asel, pos_r, free_head_r, p_r, n_r, init_cnt_r);
    prev_addr = pick_addr(cw.prev_asel, pos_r, free_head_r, p_r, n_r, init_cnt_r);
    use_addr  = pick_addr(cw.use_asel, pos_r, free_head_r, p_r, n_r, init_cnt_r);

    unique case (cw.next_wsel)
      allm_pkg::NW_FREE: next_wdata = free_head_r;
      allm_pkg::NW_NXT:  next_wdata = n_r;
      allm_pkg::NW_INIT: next_wdata = init_link;
      default:           next_wdata = n_r;
    endcase

    unique case (cw.prev_wsel)
      allm_pkg::PW_ZERO: prev_wdata = '0;
      allm_pkg::PW_POS:  prev_wdata = pos_r;
      allm_pkg::PW_FREE: prev_wdata = free_head_r;
      allm_pkg::PW_PRV:  prev_wdata = p_r;
      default:           prev_wdata = '0;
    endcase

    unique case (cw.use_wsel)
      allm_pkg::UW_CLR:  use_wdata = 1'b0;
      allm_pkg::UW_SET:  use_wdata = 1'b1;
      allm_pkg::UW_INIT: use_wdata = (init_cnt_r == '0);
      default:           use_wdata = 1'b0;
    endcase
  end

  // datapath and result next values
  always_comb begin
    init_cnt_nxt   = init_cnt_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    n_nxt          = n_r;
    p_nxt          = p_r;
    fn_nxt         = fn_r;
    free_head_nxt  = free_head_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;

    if (cw.jmp == allm_pkg::J_SWEEP) begin
      init_cnt_nxt = init_cnt_r + AW'(1);
    end

    if (accept) begin
      cmd_nxt = in_tdata[0];
      pos_nxt = in_tdata[8:1];
      val_nxt = VALUE_WIDTH'(in_tdata[40:9]);
    end

    if (adv) begin
      if (cw.cap_n) begin
        n_nxt = next_rdata;
      end
      if (cw.cap_p) begin
        p_nxt = prev_rdata;
      end
      if (cw.cap_fn) begin
        fn_nxt = next_rdata;
      end

      unique case (cw.upd)
        allm_pkg::UPD_NONE: ;
        allm_pkg::UPD_INS: begin
          free_head_nxt = fn_r;
          count_nxt     = count_r + AW'(1);
        end
        allm_pkg::UPD_DEL: begin
          free_head_nxt = pos_r;
          if (count_r != '0) begin
            count_nxt = count_r - AW'(1);
          end
        end
        default: ;
      endcase

      if (finish) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = chk_fail ? fail_status : allm_pkg::ST_OK;
        if (chk_fail) begin
          out_slot_nxt = '0;
        end else if (cw.upd == allm_pkg::UPD_INS) begin
          out_slot_nxt = 8'(free_head_r);
        end else begin
          out_slot_nxt = 8'(pos_r);
        end
        out_count_nxt = 8'(count_nxt);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= allm_pkg::S_INIT;
      init_cnt_r  <= '0;
      free_head_r <= AW'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      init_cnt_r  <= init_cnt_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    n_r          <= n_nxt;
    p_r          <= p_nxt;
    fn_r         <= fn_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  // node store: links, in-use flags, element values
  allm_ram #(.WIDTH(AW), .DEPTH(allm_pkg::ALLM_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (cw.next_we & adv),
    .addr  (next_addr),
    .wdata (next_wdata),
    .rdata (next_rdata)
  );

  allm_ram #(.WIDTH(AW), .DEPTH(allm_pkg::ALLM_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (cw.prev_we & adv),
    .addr  (prev_addr),
    .wdata (prev_wdata),
    .rdata (prev_rdata)
  );

  allm_ram #(.WIDTH(1), .DEPTH(allm_pkg::ALLM_DEPTH)) u_use_ram (
    .clk   (clk),
    .we    (cw.use_we & adv),
    .addr  (use_addr),
    .wdata (use_wdata),
    .rdata (use_rdata)
  );

  // values are held for the list contents; no operation reads them back
  allm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(allm_pkg::ALLM_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (cw.val_we & adv),
    .addr  (free_head_r),
    .wdata (val_r),
    .rdata ()
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_count_r, out_slot_r, out_status_r};

endmodule
`default_nettype wire

/* src/allm_checker.sv */
// Port-level checks for the linked list manager, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module allm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [47:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // with no result pending, none appears in the cycle right after a request is taken
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early after request");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == allm_pkg::ST_OK ||
                    out_tdata[1:0] == allm_pkg::ST_FULL ||
                    out_tdata[1:0] == allm_pkg::ST_INVALID))
    else $error("undefined status");

  // a successful request never names the sentinel
  a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == allm_pkg::ST_OK |-> out_tdata[9:2] != 8'd0)
    else $error("ok result with sentinel slot");

  // a rejected request reports slot zero
  a_err_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != allm_pkg::ST_OK |-> out_tdata[9:2] == 8'd0)
    else $error("rejected result with nonzero slot");

endmodule

bind array_linked_list_manager_core allm_checker u_allm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

/* bench/array_linked_list_manager_core_tb.sv */
// Self-checking bench for the linked list manager: insert/delete requests vs. a shadow list.
`timescale 1ns / 1ps
`default_nettype none
module array_linked_list_manager_core_tb;

  localparam int SLOTS      = allm_pkg::ALLM_DEPTH;
  localparam int MAX_ELEMS  = SLOTS - 1;   // sentinel never holds an element
  localparam int HOLD_LEN   = 400;         // long receiver hold-off, in cycles
  localparam int CYCLE_CAP  = 250000;      // run-away guard
  localparam int TAIL_WAIT  = 20;          // > one full request latency

  // packed from the top bit down: count[17:10], slot[9:2], status[1:0]
  typedef struct packed {
    logic [7:0] count;
    logic [7:0] slot;
    logic [1:0] status;
  } list_result_t;

  // Shadow of the node store: links, use bits, free chain head and element count.
  // Node values are never returned, so they are not kept.
  class list_tracker;
    logic [7:0]   fwd[SLOTS];
    logic [7:0]   back[SLOTS];
    bit           used[SLOTS];
    logic [7:0]   free_head;
    int           count;
    list_result_t pending[$];
    int           errors;
    int           n_ok, n_full, n_invalid, peak;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        fwd[i]  = (i + 1 < SLOTS) ? 8'(i + 1) : 8'd0;
        back[i] = 8'd0;
        used[i] = 1'b0;
      end
      fwd[0]    = 8'd0;
      used[0]   = 1'b1;
      free_head = 8'd1;
      count     = 0;
      errors    = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue the answer it must produce.
    function void apply_request(logic cmd, logic [7:0] pos);
      list_result_t r;
      logic [7:0] f, n, p;
      r.status = allm_pkg::ST_OK;
      r.slot   = 8'd0;
      if (cmd == allm_pkg::CMD_INSERT) begin
        if (!used[pos]) begin
          r.status = allm_pkg::ST_INVALID;
        end else if (free_head == 8'd0) begin
          r.status = allm_pkg::ST_FULL;
        end else begin
          f         = free_head;
          n         = fwd[pos];
          free_head = fwd[f];
          fwd[pos]  = f;
          back[f]   = pos;
          back[n]   = f;
          fwd[f]    = n;
          used[f]   = 1'b1;
          count++;
          r.slot    = f;
        end
      end else begin
        if (!used[pos] || pos == 8'd0) begin
          r.status = allm_pkg::ST_INVALID;
        end else begin
          p         = back[pos];
          n         = fwd[pos];
          fwd[p]    = n;
          back[n]   = p;
          back[pos] = 8'd0;
          fwd[pos]  = free_head;
          free_head = pos;
          used[pos] = 1'b0;
          if (count > 0) count--;
          r.slot    = pos;
        end
      end
      r.count = 8'(count);
      if (count > peak) peak = count;
      case (r.status)
        allm_pkg::ST_OK:   n_ok++;
        allm_pkg::ST_FULL: n_full++;
        default:           n_invalid++;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [23:0] data);
      list_result_t exp_r;
      list_result_t got;
      got = data[17:0];
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: status %0d slot %0d count %0d",
               got.status, got.slot, got.count);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.slot !== exp_r.slot) begin
        $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
        errors++;
      end
      if (got.count !== exp_r.count) begin
        $error("count: expected %0d, got %0d", exp_r.count, got.count);
        errors++;
      end
      if (data[23:18] !== 6'd0) begin
        $error("pad: expected 0, got %0h", data[23:18]);
        errors++;
      end
    endfunction

    // Random slot currently on the list; the sentinel only if allowed.
    function logic [7:0] pick_used(bit with_sentinel);
      int start;
      int s;
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
        s = (start + k) % SLOTS;
        if (used[s] && (s != 0 || with_sentinel)) return 8'(s);
      end
      return 8'd0;
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // cmd[0], position[8:1], value[40:9], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // status[1:0], slot[9:2], count[17:10], zero pad

  list_tracker tracker = new();

  int gap_pct   = 0;   // chance per cycle the sender sits idle before a request
  int stall_pct = 0;   // chance per cycle the receiver drops out_tready
  int hold_asks = 0;   // bumped by the stimulus to ask for one long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int n_sent = 0;

  array_linked_list_manager_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request so the block
  // backs up with a result pending and has to stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen  <= hold_asks;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result monitor: values seen here are the ones present at the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("array_linked_list_manager_core_tb: done, errors");
      $finish;
    end
  end

  // Offer one request, optionally after a random idle stretch, and hold it until taken.
  // The shadow list is updated at the accepting edge, so the next request is
  // generated against the state the block will see.
  task automatic send_request(input logic cmd, input logic [7:0] pos, input logic [31:0] val);
    int idle;
    idle = 0;
    while (idle < 24 && $urandom_range(0, 99) < gap_pct) idle++;
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, val, pos, cmd};
    do @(posedge clk); while (!in_tready);
    tracker.apply_request(cmd, pos);
    n_sent++;
  endtask

  // Data mix: mostly random words, some all-zero and all-one.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One random request. Most are well formed (insert after a live node, delete a
  // live element); noise_pct of them hit any slot with either command.
  task automatic random_request(input int ins_pct, input int noise_pct);
    logic cmd;
    logic [7:0] pos;
    if ($urandom_range(0, 99) < noise_pct) begin
      cmd = ($urandom_range(0, 1) == 0) ? allm_pkg::CMD_INSERT : allm_pkg::CMD_DELETE;
      pos = 8'($urandom_range(0, SLOTS - 1));
    end else if ($urandom_range(0, 99) < ins_pct || tracker.count == 0) begin
      cmd = allm_pkg::CMD_INSERT;
      pos = tracker.pick_used(1'b1);
    end else begin
      cmd = allm_pkg::CMD_DELETE;
      pos = tracker.pick_used(1'b0);
    end
    send_request(cmd, pos, pick_value());
  endtask

  // Sender pause: nothing offered until every result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rejects on an empty list, head/tail inserts with extreme values,
    // unlinking head and tail, free-slot reuse, emptying the list.
    send_request(allm_pkg::CMD_DELETE, 8'd0,   32'h1234_5678);  // sentinel can't be deleted
    send_request(allm_pkg::CMD_DELETE, 8'd5,   32'h0);          // unused slot
    send_request(allm_pkg::CMD_INSERT, 8'd7,   32'h0);          // insert after unused slot
    send_request(allm_pkg::CMD_INSERT, 8'd0,   32'h0000_0000);  // first element -> slot 1
    send_request(allm_pkg::CMD_INSERT, 8'd0,   32'hFFFF_FFFF);  // new head -> slot 2
    send_request(allm_pkg::CMD_INSERT, 8'd1,   32'hA5A5_A5A5);  // after tail -> slot 3
    send_request(allm_pkg::CMD_INSERT, 8'd255, 32'h5A5A_5A5A);  // highest slot, unused
    send_request(allm_pkg::CMD_DELETE, 8'd2,   32'hFFFF_FFFF);  // unlink head
    send_request(allm_pkg::CMD_DELETE, 8'd2,   32'h0);          // already freed
    send_request(allm_pkg::CMD_DELETE, 8'd3,   32'h0);          // unlink tail
    send_request(allm_pkg::CMD_INSERT, 8'd0,   32'h8000_0001);  // reuses last freed slot
    send_request(allm_pkg::CMD_INSERT, 8'd3,   32'h7FFF_FFFE);  // after the reused slot
    send_request(allm_pkg::CMD_DELETE, 8'd1,   32'h0);
    send_request(allm_pkg::CMD_DELETE, 8'd3,   32'h0);
    send_request(allm_pkg::CMD_DELETE, 8'd2,   32'h0);          // list empty again
    send_request(allm_pkg::CMD_DELETE, 8'd255, 32'h0);
    send_request(allm_pkg::CMD_INSERT, 8'd0,   32'h0000_0001);
    wait_drained();

    // No idling: fill the store completely, then knock on it while full.
    // A long receiver hold-off at the start backs the block up.
    gap_pct   = 0;
    stall_pct = 0;
    hold_asks++;
    while (tracker.count < MAX_ELEMS) random_request(100, 4);
    repeat (8) random_request(100, 0);
    wait_drained();

    // Sender idling, list draining.
    gap_pct   = 60;
    stall_pct = 0;
    repeat (260) random_request(12, 8);
    wait_drained();

    // Receiver stalling, balanced churn.
    gap_pct   = 0;
    stall_pct = 60;
    repeat (200) random_request(50, 10);
    wait_drained();

    // Both sides idling, churn with more noise.
    gap_pct   = 33;
    stall_pct = 33;
    repeat (200) random_request(55, 20);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d requests: %0d ok, %0d full, %0d invalid",
             n_sent, tracker.n_ok, tracker.n_full, tracker.n_invalid);
    $display("list peaked at %0d elements, ended with %0d", tracker.peak, tracker.count);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("array_linked_list_manager_core_tb: done, clean");
    end else begin
      $display("array_linked_list_manager_core_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
